// ----- rtl/ttfc_pkg.sv -----
package ttfc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_ZERO_OFFSET   = 3'd0;
    localparam logic [2:0] CFG_FLOW_CONSTANT = 3'd1;
    localparam logic [2:0] CFG_DEAD_HIGH     = 3'd2;
    localparam logic [2:0] CFG_DEAD_LOW      = 3'd3;
    localparam logic [2:0] CFG_FULL_SCALE    = 3'd4;
    localparam logic [2:0] CFG_KNOT_SPEEDS   = 3'd5;
    localparam logic [2:0] CFG_KNOT_GAINS    = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_NORMAL  = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_DEAD    = 2'd2;
    localparam logic [1:0] ST_CLAMP   = 2'd3;

    // Flow scaling: 3600 * 2^20 applied to the numerator
    localparam logic [11:0] HOUR_SECONDS = 12'd3600;
    localparam int          NUM_SHIFT    = 20;

    // Flow division widths
    localparam int FLOW_NUM_W = 97;
    localparam int FLOW_DEN_W = 66;
    localparam int FLOW_Q_W   = 31;

    // Gain interpolation division widths
    localparam int GAIN_NUM_W = 44;
    localparam int GAIN_DEN_W = 28;
    localparam int GAIN_Q_W   = 16;

    typedef enum logic [2:0] {
        ZONE_DEAD,
        ZONE_K0,
        ZONE_I01,
        ZONE_I12,
        ZONE_K2,
        ZONE_CLAMP
    } zone_t;

    typedef struct packed {
        logic inv;
        logic neg;
        logic sat;
    } front_side_t;

    typedef struct packed {
        logic [31:0] raw;
        logic        inv;
        zone_t       zone;
        logic [31:0] mag;
        logic [15:0] ka;
        logic        dneg;
    } gain_side_t;

endpackage

// ----- rtl/ttfc_div.sv -----
module ttfc_div
    import ttfc_pkg::*;
#(
    parameter int NUM_W  = 44,
    parameter int DEN_W  = 28,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quot,
    output logic [SIDE_W-1:0] side_out
);

    // One quotient bit per stage; num must stay below den << Q_W
    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic              v_reg    [Q_W];
    logic [NUM_W-1:0]  rem_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [Q_W-1:0]    q_reg    [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_step
        localparam int B = Q_W - 1 - j;
        logic              v_in;
        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    q_in;
        logic [SIDE_W-1:0] side_in;
        logic [CW-1:0]     rem_w;
        logic [CW-1:0]     trial;
        logic [CW-1:0]     diff;
        logic              fit;

        if (j == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = num;
            assign den_in  = den;
            assign q_in    = '0;
            assign side_in = side;
        end else begin : g_next
            assign v_in    = v_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        assign rem_w = CW'(rem_in);
        assign trial = CW'(den_in) << B;
        assign fit   = rem_w >= trial;
        assign diff  = rem_w - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= fit ? diff[NUM_W-1:0] : rem_in;
                den_reg[j]  <= den_in;
                q_reg[j]    <= q_in | (fit ? (Q_W'(1) << B) : Q_W'(0));
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign quot      = q_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

// ----- rtl/ttfc_front.sv -----
module ttfc_front
    import ttfc_pkg::*;
#(
    parameter int unsigned TIME_MIN = 1,
    parameter int unsigned TIME_MAX = 16777215
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [31:0]           time_up,
    input  logic [31:0]           time_down,
    input  logic [31:0]           zero_offset,
    input  logic [31:0]           flow_constant,
    output logic                  out_valid,
    output logic [FLOW_NUM_W-1:0] num,
    output logic [FLOW_DEN_W-1:0] den,
    output front_side_t           side
);

    localparam logic [23:0] T_LO = 24'(TIME_MIN);
    localparam logic [23:0] T_HI = 24'(TIME_MAX);

    logic        ok_up;
    logic        ok_down;
    logic [33:0] diff;
    logic [33:0] diff_mag;
    logic [FLOW_NUM_W-1:0] num_full;
    logic [FLOW_NUM_W-1:0] den_shift;
    logic        sat;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        inv1_reg, inv2_reg, inv3_reg;
    logic        neg1_reg, neg2_reg, neg3_reg;
    logic [32:0] mag1_reg;
    logic [32:0] sum1_reg;
    logic [64:0] prod2_reg;
    logic [65:0] sq2_reg;
    logic [76:0] prod3_reg;
    logic [65:0] sq3_reg;
    logic [FLOW_NUM_W-1:0] num4_reg;
    logic [FLOW_DEN_W-1:0] den4_reg;
    front_side_t side4_reg;

    assign ok_up    = (time_up[31:8] >= T_LO) && (time_up[31:8] <= T_HI);
    assign ok_down  = (time_down[31:8] >= T_LO) && (time_down[31:8] <= T_HI);
    assign diff     = {2'b00, time_up} - {2'b00, time_down}
                      - {{2{zero_offset[31]}}, zero_offset};
    assign diff_mag = diff[33] ? (34'd0 - diff) : diff;

    assign num_full  = {prod3_reg, {NUM_SHIFT{1'b0}}};
    assign den_shift = {sq3_reg, 31'd0};
    assign sat       = num_full >= den_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv1_reg  <= !(ok_up && ok_down);
            neg1_reg  <= diff[33];
            mag1_reg  <= diff_mag[32:0];
            sum1_reg  <= {1'b0, time_up} + {1'b0, time_down};

            inv2_reg  <= inv1_reg;
            neg2_reg  <= neg1_reg;
            prod2_reg <= mag1_reg * flow_constant;
            sq2_reg   <= sum1_reg * sum1_reg;

            inv3_reg  <= inv2_reg;
            neg3_reg  <= neg2_reg;
            prod3_reg <= prod2_reg * HOUR_SECONDS;
            sq3_reg   <= sq2_reg;

            // drop the numerator on overflow so the divider stays in range
            num4_reg       <= sat ? '0 : num_full;
            den4_reg       <= sq3_reg;
            side4_reg.inv  <= inv3_reg;
            side4_reg.neg  <= neg3_reg;
            side4_reg.sat  <= sat;
        end
    end

    assign out_valid = v4_reg;
    assign num       = num4_reg;
    assign den       = den4_reg;
    assign side      = side4_reg;

endmodule

// ----- rtl/ttfc_gain.sv -----
module ttfc_gain
    import ttfc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [FLOW_Q_W-1:0] quot,
    input  front_side_t         fside,
    input  logic [31:0]         dead_zone_high,
    input  logic [31:0]         dead_zone_low,
    input  logic [30:0]         full_scale,
    input  logic [47:0]         knot_speeds,
    input  logic [47:0]         knot_gains,
    output logic                out_valid,
    output logic [31:0]         volume,
    output logic [31:0]         raw_volume,
    output logic [1:0]          status
);

    logic [31:0] raw_c;
    logic [31:0] mag_c;
    logic [27:0] kv0, kv1, kv2;
    logic        dead;
    zone_t       zone_c;
    logic [15:0] ka_c, kb_c;
    logic [27:0] va_c, vb_c;
    logic [16:0] dmag_c;
    logic        interp2;
    logic        interp3;
    logic [15:0] gain_c;
    logic [33:0] scaled;
    logic [31:0] vol_c;
    logic [1:0]  st_c;

    logic        v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic        inv0_reg, inv1_reg;
    logic [31:0] raw0_reg, raw1_reg;
    zone_t       zone1_reg;
    logic [31:0] mag1_reg;
    logic [15:0] ka1_reg;
    logic [16:0] dk1_reg;
    logic [27:0] av1_reg;
    logic [27:0] w1_reg;
    logic [GAIN_NUM_W-1:0] prod2_reg;
    logic [GAIN_DEN_W-1:0] w2_reg;
    gain_side_t  side2_reg;

    logic                div_valid;
    logic [GAIN_Q_W-1:0] div_q;
    gain_side_t          div_side;

    logic [31:0] raw3_reg, raw4_reg;
    logic        inv3_reg, inv4_reg;
    zone_t       zone3_reg, zone4_reg;
    logic [31:0] mag3_reg;
    logic [15:0] g3_reg;
    logic [47:0] p4_reg;
    logic [31:0] vol5_reg, raw5_reg;
    logic [1:0]  st5_reg;

    // Saturated signed raw flow from the quotient; zero for an invalid item
    always_comb
    begin
        if (fside.inv)
        begin
            raw_c = '0;
        end
        else if (fside.sat)
        begin
            raw_c = fside.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else if (fside.neg)
        begin
            raw_c = 32'd0 - {1'b0, quot};
        end
        else
        begin
            raw_c = {1'b0, quot};
        end
    end

    assign mag_c = raw0_reg[31] ? (32'd0 - raw0_reg) : raw0_reg;
    assign kv0   = {knot_speeds[15:0], 12'd0};
    assign kv1   = {knot_speeds[31:16], 12'd0};
    assign kv2   = {knot_speeds[47:32], 12'd0};
    assign dead  = ($signed(raw0_reg) < $signed(dead_zone_high))
                   && ($signed(raw0_reg) > $signed(dead_zone_low));

    // Pick the zone by magnitude after the signed dead-zone test; the dead zone wins over every knot
    always_comb
    begin
        ka_c = knot_gains[15:0];
        kb_c = knot_gains[15:0];
        va_c = '0;
        vb_c = '0;
        priority if (dead)
        begin
            zone_c = ZONE_DEAD;
        end
        else if (mag_c < {4'd0, kv0})
        begin
            zone_c = ZONE_K0;
        end
        else if (mag_c < {4'd0, kv1})
        begin
            zone_c = ZONE_I01;
            kb_c   = knot_gains[31:16];
            va_c   = kv0;
            vb_c   = kv1;
        end
        else if (mag_c < {4'd0, kv2})
        begin
            zone_c = ZONE_I12;
            ka_c   = knot_gains[31:16];
            kb_c   = knot_gains[47:32];
            va_c   = kv1;
            vb_c   = kv2;
        end
        else if (mag_c < {1'b0, full_scale})
        begin
            zone_c = ZONE_K2;
            ka_c   = knot_gains[47:32];
            kb_c   = knot_gains[47:32];
        end
        else
        begin
            zone_c = ZONE_CLAMP;
        end
    end

    assign interp2 = (zone1_reg == ZONE_I01) || (zone1_reg == ZONE_I12);
    assign dmag_c  = dk1_reg[16] ? (17'd0 - dk1_reg) : dk1_reg;
    assign interp3 = (div_side.zone == ZONE_I01) || (div_side.zone == ZONE_I12);
    assign gain_c  = !interp3 ? div_side.ka
                   : (div_side.dneg ? div_side.ka - div_q : div_side.ka + div_q);

    assign scaled = p4_reg[47:14];

    always_comb
    begin
        vol_c = '0;
        st_c  = ST_NORMAL;
        if (inv4_reg)
        begin
            st_c = ST_INVALID;
        end
        else if (zone4_reg == ZONE_DEAD)
        begin
            st_c = ST_DEAD;
        end
        else if (zone4_reg == ZONE_CLAMP)
        begin
            st_c  = ST_CLAMP;
            vol_c = raw4_reg[31] ? (32'd0 - {1'b0, full_scale}) : {1'b0, full_scale};
        end
        else if (raw4_reg[31])
        begin
            if (scaled > 34'h0_8000_0000)
            begin
                st_c  = ST_CLAMP;
                vol_c = 32'h8000_0000;
            end
            else
            begin
                vol_c = 32'd0 - scaled[31:0];
            end
        end
        else if (scaled > 34'h0_7FFF_FFFF)
        begin
            st_c  = ST_CLAMP;
            vol_c = 32'h7FFF_FFFF;
        end
        else
        begin
            vol_c = scaled[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= div_valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv0_reg  <= fside.inv;
            raw0_reg  <= raw_c;

            inv1_reg  <= inv0_reg;
            raw1_reg  <= raw0_reg;
            zone1_reg <= zone_c;
            mag1_reg  <= mag_c;
            ka1_reg   <= ka_c;
            dk1_reg   <= {1'b0, kb_c} - {1'b0, ka_c};
            av1_reg   <= mag_c[27:0] - va_c;
            w1_reg    <= vb_c - va_c;

            prod2_reg      <= interp2 ? dmag_c[15:0] * av1_reg : '0;
            w2_reg         <= w1_reg;
            side2_reg.raw  <= raw1_reg;
            side2_reg.inv  <= inv1_reg;
            side2_reg.zone <= zone1_reg;
            side2_reg.mag  <= mag1_reg;
            side2_reg.ka   <= ka1_reg;
            side2_reg.dneg <= dk1_reg[16];

            raw3_reg  <= div_side.raw;
            inv3_reg  <= div_side.inv;
            zone3_reg <= div_side.zone;
            mag3_reg  <= div_side.mag;
            g3_reg    <= gain_c;

            raw4_reg  <= raw3_reg;
            inv4_reg  <= inv3_reg;
            zone4_reg <= zone3_reg;
            p4_reg    <= mag3_reg * g3_reg;

            vol5_reg  <= vol_c;
            raw5_reg  <= raw4_reg;
            st5_reg   <= st_c;
        end
    end

    ttfc_div #(
        .NUM_W  (GAIN_NUM_W),
        .DEN_W  (GAIN_DEN_W),
        .Q_W    (GAIN_Q_W),
        .SIDE_W ($bits(gain_side_t))
    ) u_gain_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .num       (prod2_reg),
        .den       (w2_reg),
        .side      (side2_reg),
        .out_valid (div_valid),
        .quot      (div_q),
        .side_out  (div_side)
    );

    assign out_valid  = v5_reg;
    assign volume     = vol5_reg;
    assign raw_volume = raw5_reg;
    assign status     = st5_reg;

endmodule

// ----- rtl/transit_time_flow_calibrator.sv -----
// Transit-time flow calibrator: each item (upstream and downstream transit time, Q24.8)
// yields one result (corrected flow, raw flow, status); a new item is taken every cycle
// while the result is not held. The depth is set by the flow division, one quotient bit
// per stage over 31 stages, and the gain interpolation division, 16 stages, plus 10 stages
// of range checks, multipliers and the gain curve. When the result is not taken the whole
// pipeline holds and s_axis_tready falls in the same cycle. Write configuration only
// while no item is in flight.
module transit_time_flow_calibrator
    import ttfc_pkg::*;
#(
    parameter int unsigned TIME_MIN = 1,
    parameter int unsigned TIME_MAX = 16777215
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] time_up, [63:32] time_down
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] volume, [63:32] raw_volume, [65:64] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    logic        en;
    logic [31:0] zero_offset_reg;
    logic [31:0] flow_constant_reg;
    logic [31:0] dead_high_reg;
    logic [31:0] dead_low_reg;
    logic [30:0] full_scale_reg;
    logic [47:0] knot_speeds_reg;
    logic [47:0] knot_gains_reg;

    logic                  f_valid;
    logic [FLOW_NUM_W-1:0] f_num;
    logic [FLOW_DEN_W-1:0] f_den;
    front_side_t           f_side;
    logic                  d_valid;
    logic [FLOW_Q_W-1:0]   d_quot;
    front_side_t           d_side;
    logic [31:0]           volume;
    logic [31:0]           raw_volume;
    logic [1:0]            status;

    // Advance everything unless the result register is held
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg   <= '0;
            flow_constant_reg <= '0;
            dead_high_reg     <= '0;
            dead_low_reg      <= '0;
            full_scale_reg    <= 31'h7FFF_FFFF;
            knot_speeds_reg   <= '0;
            knot_gains_reg    <= 48'h4000_4000_4000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ZERO_OFFSET:   zero_offset_reg   <= cfg_data[31:0];
                CFG_FLOW_CONSTANT: flow_constant_reg <= cfg_data[31:0];
                CFG_DEAD_HIGH:     dead_high_reg     <= cfg_data[31:0];
                CFG_DEAD_LOW:      dead_low_reg      <= cfg_data[31:0];
                CFG_FULL_SCALE:    full_scale_reg    <= cfg_data[30:0];
                CFG_KNOT_SPEEDS:   knot_speeds_reg   <= cfg_data;
                CFG_KNOT_GAINS:    knot_gains_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    ttfc_front #(
        .TIME_MIN (TIME_MIN),
        .TIME_MAX (TIME_MAX)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_axis_tvalid),
        .time_up       (s_axis_tdata[31:0]),
        .time_down     (s_axis_tdata[63:32]),
        .zero_offset   (zero_offset_reg),
        .flow_constant (flow_constant_reg),
        .out_valid     (f_valid),
        .num           (f_num),
        .den           (f_den),
        .side          (f_side)
    );

    ttfc_div #(
        .NUM_W  (FLOW_NUM_W),
        .DEN_W  (FLOW_DEN_W),
        .Q_W    (FLOW_Q_W),
        .SIDE_W ($bits(front_side_t))
    ) u_flow_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .num       (f_num),
        .den       (f_den),
        .side      (f_side),
        .out_valid (d_valid),
        .quot      (d_quot),
        .side_out  (d_side)
    );

    ttfc_gain u_gain (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (d_valid),
        .quot           (d_quot),
        .fside          (d_side),
        .dead_zone_high (dead_high_reg),
        .dead_zone_low  (dead_low_reg),
        .full_scale     (full_scale_reg),
        .knot_speeds    (knot_speeds_reg),
        .knot_gains     (knot_gains_reg),
        .out_valid      (m_axis_tvalid),
        .volume         (volume),
        .raw_volume     (raw_volume),
        .status         (status)
    );

    assign m_axis_tdata = {6'd0, status, raw_volume, volume};

endmodule

// ----- rtl/ttfc_checker.sv -----
module ttfc_checker
    import ttfc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[65:64] == ST_INVALID)
        |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("invalid time gave non-zero flow");

    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[65:64] == ST_DEAD)
        |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("dead zone gave non-zero volume");

endmodule

bind transit_time_flow_calibrator ttfc_checker u_ttfc_checker (.*);
